FILE: rtl/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, ignored while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// clocked property that is also checked during reset
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

FILE: rtl/rc4_pkg.sv
// package with shared types and constants of the rc4 stream cipher
package rc4_pkg;

    localparam int PERM_DEPTH = 256;
    localparam int ADDR_W     = $clog2(PERM_DEPTH);
    localparam int KEY_BYTES  = 4;
    localparam int KEY_SEL_W  = $clog2(KEY_BYTES);
    localparam int KEY_W      = 8 * KEY_BYTES;

    // action codes
    localparam logic ACT_KEY  = 1'b0;
    localparam logic ACT_DATA = 1'b1;

    // sequencer states, one-hot
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_G_RI  = 11'b000_0000_0010,
        ST_G_RJ  = 11'b000_0000_0100,
        ST_G_WI  = 11'b000_0000_1000,
        ST_G_WJ  = 11'b000_0001_0000,
        ST_G_RK  = 11'b000_0010_0000,
        ST_G_OUT = 11'b000_0100_0000,
        ST_K_RN  = 11'b000_1000_0000,
        ST_K_RJ  = 11'b001_0000_0000,
        ST_K_WN  = 11'b010_0000_0000,
        ST_K_WJ  = 11'b100_0000_0000
    } state_t;

    // request from the sequencer to the permutation memory
    typedef struct packed {
        logic              clear;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } mem_req_t;

endpackage

FILE: rtl/rc4_perm_mem.sv
// permutation memory with per-entry valid bits, invalid entries read as identity
module rc4_perm_mem
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  rc4_pkg::mem_req_t         req,
    output logic [rc4_pkg::ADDR_W-1:0] rd_data
);

    logic [7:0]                    mem [rc4_pkg::PERM_DEPTH];
    logic [rc4_pkg::PERM_DEPTH-1:0] valid_reg;
    logic [7:0]                    mem_q_reg;
    logic                          hit_reg;
    logic [rc4_pkg::ADDR_W-1:0]    addr_q_reg;

    // storage array, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            mem_q_reg  <= mem[req.rd_addr];
            addr_q_reg <= req.rd_addr;
        end
    end

    // valid bits, cleared at once by reset or a key schedule
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (req.clear)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                hit_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // unwritten entry holds its own index
    assign rd_data = hit_reg ? mem_q_reg : addr_q_reg;

endmodule

FILE: rtl/rc4_stream_cipher_top.sv
// A data item makes one memory access per state (two reads, two swap writes, one keystream
// read), and data_out is registered once the output register is free; no item is taken meanwhile.
// A key-schedule item keeps in_stall high through 256 mixing steps (read S[n], read S[j], two
// swap writes each), gives no result, and the next item is taken only after the last step.
// Reset (rst_n, async, low) clears the sequencer, indices, key and all table valid bits,
// so the table reads as identity at once; no clearing pass is needed.
module rc4_stream_cipher_top
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     action,
    input  logic [7:0]               data_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [7:0]               data_out,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [rc4_pkg::KEY_W-1:0] cfg_key
);

    localparam int AW = rc4_pkg::ADDR_W;

    rc4_pkg::state_t   state_reg, state_next;
    logic [AW-1:0]     i_reg, i_next;
    logic [AW-1:0]     j_reg, j_next;
    logic [AW-1:0]     n_reg, n_next;
    logic [7:0]        si_reg, si_next;
    logic [7:0]        sj_reg, sj_next;
    logic [7:0]        din_reg, din_next;
    logic [rc4_pkg::KEY_W-1:0] key_reg;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        data_out_reg, data_out_next;

    rc4_pkg::mem_req_t mem_req;
    logic [AW-1:0]     rd_data;
    logic [7:0]        key_byte;
    logic [AW-1:0]     gen_j;
    logic [AW-1:0]     mix_j;
    logic [AW-1:0]     ks_addr;
    logic              in_accept;
    logic              out_free;

    assign in_stall  = (state_reg != rc4_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // datapath sums, all modulo the table size
    assign key_byte = key_reg[{n_reg[rc4_pkg::KEY_SEL_W-1:0], 3'b000} +: 8];
    assign gen_j    = AW'(j_reg + rd_data);
    assign mix_j    = AW'(j_reg + rd_data + key_byte);
    assign ks_addr  = AW'(si_reg + sj_reg);

    rc4_perm_mem u_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // sequencer next state and memory requests
    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        din_next       = din_reg;
        out_valid_next = out_valid_reg && out_stall;
        data_out_next  = data_out_reg;
        mem_req        = '0;

        case (state_reg)
            rc4_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    din_next = data_in;
                    if (action == rc4_pkg::ACT_KEY)
                    begin
                        mem_req.clear = 1'b1;
                        j_next        = '0;
                        n_next        = '0;
                        state_next    = rc4_pkg::ST_K_RN;
                    end
                    else
                    begin
                        i_next     = AW'(i_reg + 1'b1);
                        state_next = rc4_pkg::ST_G_RI;
                    end
                end
            end
            // generator: read S[i]
            rc4_pkg::ST_G_RI:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = i_reg;
                state_next      = rc4_pkg::ST_G_RJ;
            end
            // S[i] back, advance j and read S[j]
            rc4_pkg::ST_G_RJ:
            begin
                si_next         = rd_data;
                j_next          = gen_j;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = gen_j;
                state_next      = rc4_pkg::ST_G_WI;
            end
            // swap, first half
            rc4_pkg::ST_G_WI:
            begin
                sj_next         = rd_data;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = i_reg;
                mem_req.wr_data = rd_data;
                state_next      = rc4_pkg::ST_G_WJ;
            end
            // swap, second half
            rc4_pkg::ST_G_WJ:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = j_reg;
                mem_req.wr_data = si_reg;
                state_next      = rc4_pkg::ST_G_RK;
            end
            // keystream read
            rc4_pkg::ST_G_RK:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = ks_addr;
                state_next      = rc4_pkg::ST_G_OUT;
            end
            // result into the output register once it is free
            rc4_pkg::ST_G_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    data_out_next  = din_reg ^ rd_data;
                    state_next     = rc4_pkg::ST_IDLE;
                end
            end
            // key schedule: read S[n]
            rc4_pkg::ST_K_RN:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = n_reg;
                state_next      = rc4_pkg::ST_K_RJ;
            end
            // mix j with the key byte and read S[j]
            rc4_pkg::ST_K_RJ:
            begin
                si_next         = rd_data;
                j_next          = mix_j;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = mix_j;
                state_next      = rc4_pkg::ST_K_WN;
            end
            rc4_pkg::ST_K_WN:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = n_reg;
                mem_req.wr_data = rd_data;
                state_next      = rc4_pkg::ST_K_WJ;
            end
            // finish the swap, step n, restart indices after the last step
            rc4_pkg::ST_K_WJ:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = j_reg;
                mem_req.wr_data = si_reg;
                n_next          = AW'(n_reg + 1'b1);
                if (n_reg == AW'(rc4_pkg::PERM_DEPTH - 1))
                begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = rc4_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rc4_pkg::ST_K_RN;
                end
            end
            default:
            begin
                state_next = rc4_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4_pkg::ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            key_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                key_reg <= cfg_key;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        din_reg      <= din_next;
        data_out_reg <= data_out_next;
    end

endmodule

FILE: rtl/rc4_checker.sv
// port-level checker for the rc4 stream cipher, bound to the top level
`include "assert_macros.svh"

module rc4_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       action,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] data_out
);

    // a held result keeps its value
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(data_out))
    // an accepted item keeps the block busy
    `ASSERT_CLK(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall)
    // a key schedule does not produce a result right away
    `ASSERT_CLK(a_key_no_result, clk, rst_n, in_valid && !in_stall && !action && !out_valid |=> !out_valid)
    // no result right out of reset
    `ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid)

endmodule

bind rc4_stream_cipher_top rc4_checker u_rc4_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .data_out  (data_out)
);

FILE: tb/sv/rc4_stream_cipher_top_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the rc4 stream cipher: directed and random items against a predictor

// keeps its own copy of the cipher state and the bytes still owed by the block
class rc4_scoreboard;
    logic [7:0]  perm [256];
    logic [7:0]  gen_i;
    logic [7:0]  gen_j;
    logic [31:0] key_reg;
    logic [7:0]  expected_bytes [$];
    int          mismatches;
    int          results_seen;
    int          data_items;
    int          key_items;
    int          key_writes;

    function new();
        load_identity();
        gen_i        = 8'd0;
        gen_j        = 8'd0;
        key_reg      = 32'd0;
        mismatches   = 0;
        results_seen = 0;
        data_items   = 0;
        key_items    = 0;
        key_writes   = 0;
    endfunction

    function void load_identity();
        for (int n = 0; n < 256; n++)
        begin
            perm[n] = 8'(n);
        end
    endfunction

    // key schedule: identity, 256 mixing swaps with the key repeated every four bytes
    function void mix_key();
        logic [7:0] j;
        logic [7:0] kb;
        logic [7:0] t;
        load_identity();
        j = 8'd0;
        for (int n = 0; n < 256; n++)
        begin
            kb      = key_reg[8 * (n % 4) +: 8];
            j       = j + perm[n] + kb;
            t       = perm[n];
            perm[n] = perm[j];
            perm[j] = t;
        end
        gen_i = 8'd0;
        gen_j = 8'd0;
    endfunction

    // one generator step, returns the keystream byte
    function logic [7:0] next_keystream();
        logic [7:0] t;
        gen_i       = gen_i + 8'd1;
        gen_j       = gen_j + perm[gen_i];
        t           = perm[gen_i];
        perm[gen_i] = perm[gen_j];
        perm[gen_j] = t;
        t           = perm[gen_i] + perm[gen_j];
        return perm[t];
    endfunction

    function void note_input(logic act, logic [7:0] byte_in);
        if (act == rc4_pkg::ACT_KEY)
        begin
            mix_key();
            key_items++;
        end
        else
        begin
            expected_bytes.push_back(byte_in ^ next_keystream());
            data_items++;
        end
    endfunction

    function void check_result(logic [7:0] got);
        logic [7:0] want;
        results_seen++;
        if (expected_bytes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: data_out %h arrived with no byte pending", got);
        end
        else
        begin
            want = expected_bytes.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d data_out expected %h got %h",
                             results_seen, want, got);
            end
        end
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction
endclass

module rc4_stream_cipher_top_test;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 1100;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASE_ITEMS    = 150;
    localparam int PHASES         = 6;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              action     = rc4_pkg::ACT_DATA;
    logic [7:0]        data_in    = 8'd0;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    logic [7:0]        data_out;
    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic [rc4_pkg::KEY_W-1:0] cfg_key = '0;

    rc4_scoreboard     sb;
    bit                burst_mode = 1'b0;
    int                idle_cycles = 0;

    rc4_stream_cipher_top uut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .data_in    (data_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .data_out   (data_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_key    (cfg_key)
    );

    always #HALF_PERIOD clk = ~clk;

    // receiver stalls at random outside the burst stretch
    always @(posedge clk)
    begin
        out_stall <= !burst_mode && ($urandom_range(99) < 36);
    end

    // mid-cycle monitor: everything seen here is accepted at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(data_out);
            if (in_valid && !in_stall)
                sb.note_input(action, data_in);
            if (cfg_valid && cfg_ready)
            begin
                sb.key_reg = cfg_key;
                sb.key_writes++;
            end
            if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles > WATCHDOG_LIMIT)
            begin
                $display("timeout: nothing moved for %0d cycles, %0d bytes pending",
                         idle_cycles, sb.pending());
                $display("Verification failed");
                $finish;
            end
        end
    end

    // mostly uniform bytes, with the two extremes favored
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 8'h00;
        else if (r < 16)
            return 8'hff;
        return 8'($urandom_range(255));
    endfunction

    // present one item, with random gaps first outside the burst stretch, and hold it until accepted
    task automatic send_item(input logic act, input logic [7:0] byte_val);
        logic stalled;
        if (!burst_mode)
        begin
            while ($urandom_range(99) < 36)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        action   <= act;
        data_in  <= byte_val;
        stalled = 1'b1;
        while (stalled)
        begin
            @(negedge clk);
            stalled = in_stall;
            @(posedge clk);
        end
    endtask

    // stop sending and wait for every owed byte, then wait the settle time so a key schedule can finish
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // key register write, only ever called with the block idle
    task automatic write_key(input logic [rc4_pkg::KEY_W-1:0] key_val);
        logic ready_seen;
        cfg_valid <= 1'b1;
        cfg_key   <= key_val;
        ready_seen = 1'b0;
        while (!ready_seen)
        begin
            @(negedge clk);
            ready_seen = cfg_ready;
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // well-formed runs: key schedule then data, plus data with no fresh schedule
    // and back-to-back schedules now and then
    task automatic run_phase(input int n_items);
        int sent;
        int run_len;
        int r;
        bit paused;
        sent   = 0;
        paused = 1'b0;
        while (sent < n_items)
        begin
            r = $urandom_range(99);
            if (r < 88)
            begin
                send_item(rc4_pkg::ACT_KEY, 8'($urandom_range(255)));
                sent++;
            end
            if (r >= 80 && r < 88)
            begin
                send_item(rc4_pkg::ACT_KEY, 8'($urandom_range(255)));
                sent++;
            end
            run_len = $urandom_range(40, 1);
            repeat (run_len)
            begin
                send_item(rc4_pkg::ACT_DATA, pick_byte());
                sent++;
            end
            // sender holds off once per phase until the block has caught up
            if (!paused && sent >= n_items / 2)
            begin
                drain(0);
                paused = 1'b1;
            end
        end
    endtask

    initial
    begin
        logic [rc4_pkg::KEY_W-1:0] phase_key;
        sb = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // data on the reset table before any key schedule
        send_item(rc4_pkg::ACT_DATA, 8'h00);
        send_item(rc4_pkg::ACT_DATA, 8'hff);
        send_item(rc4_pkg::ACT_DATA, 8'ha5);
        // schedule with the reset key, data byte ignored
        send_item(rc4_pkg::ACT_KEY, 8'hff);
        send_item(rc4_pkg::ACT_DATA, 8'h00);
        send_item(rc4_pkg::ACT_DATA, 8'hff);
        drain(SETTLE_CYCLES);

        // new key has no effect until the next schedule
        write_key(32'hffff_ffff);
        send_item(rc4_pkg::ACT_DATA, 8'h5a);
        send_item(rc4_pkg::ACT_KEY, 8'h00);
        send_item(rc4_pkg::ACT_DATA, 8'h00);
        send_item(rc4_pkg::ACT_DATA, 8'hff);
        send_item(rc4_pkg::ACT_DATA, 8'h01);
        send_item(rc4_pkg::ACT_DATA, 8'h80);
        drain(SETTLE_CYCLES);

        // two schedules in a row
        write_key(32'h0123_4567);
        send_item(rc4_pkg::ACT_KEY, 8'h33);
        send_item(rc4_pkg::ACT_KEY, 8'hcc);
        send_item(rc4_pkg::ACT_DATA, 8'h7f);
        send_item(rc4_pkg::ACT_DATA, 8'h00);
        drain(SETTLE_CYCLES);

        // random phases, each under its own key; third phase has no random gaps or receiver stalls
        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                phase_key = 32'h0000_0000;
            else if (p == 1)
                phase_key = 32'hffff_ffff;
            else
                phase_key = $urandom;
            write_key(phase_key);
            burst_mode = (p == 2);
            run_phase(PHASE_ITEMS);
            drain(SETTLE_CYCLES);
            burst_mode = 1'b0;
        end

        $display("covered %0d data bytes and %0d key schedules under %0d key writes",
                 sb.data_items, sb.key_items, sb.key_writes);
        $display("%0d results checked, %0d mismatches, %0d bytes still pending",
                 sb.results_seen, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
